// ----- src/crcbe_pkg.sv -----
// crcbe_pkg: shared types, constants and the byte fold function for the crc-8 engine
// no dependencies; imported by every module of the block

package crcbe_pkg;

   localparam logic [7:0] CRC_INIT      = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL = 8'hB8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } byte_item_type;

   // one byte through the reflected table, then inverted
   function automatic logic [7:0] crc_fold(input logic [7:0] cur, input logic [7:0] data);
      logic [7:0] v;
      v = cur ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY_REFL;
         end else begin
            v = v >> 1;
         end
      end
      return ~v;
   endfunction

endpackage

// ----- src/crcbe_in_stage.sv -----
// crcbe_in_stage: input register holding one accepted byte and its flags
// depends on crcbe_pkg

module crcbe_in_stage
   import crcbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  byte_item_type req_item,
   input  logic          stage_take,
   output logic          stage_valid,
   output byte_item_type stage_item
);

   logic          valid_ff;
   logic          valid_in;
   byte_item_type item_ff;

   assign req_ready = !valid_ff || stage_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !stage_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ----- src/crcbe_core.sv -----
// crcbe_core: running crc register, byte fold and result register
// depends on crcbe_pkg

module crcbe_core
   import crcbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          stage_valid,
   input  byte_item_type stage_item,
   output logic          stage_take,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_crc_value
);

   logic [7:0] crc_ff;
   logic [7:0] crc_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_crc_ff;
   logic [7:0] fold_cur;
   logic [7:0] fold_res;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_ready;
   // only a last byte needs room in the result register
   assign stage_take = stage_valid && (!stage_item.last_byte || out_free);

   assign fold_cur = stage_item.first_byte ? CRC_INIT : crc_ff;
   assign fold_res = crc_fold(fold_cur, stage_item.data_byte);

   always_comb begin
      crc_in = crc_ff;
      if (stage_take) begin
         crc_in = stage_item.last_byte ? CRC_INIT : fold_res;
      end
   end

   assign out_valid_in = (stage_take && stage_item.last_byte) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take && stage_item.last_byte) begin
         out_crc_ff <= fold_res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

endmodule

// ----- src/crc8_reflected_byte_engine_unit.sv -----
// crc8_reflected_byte_engine_unit: top level of the byte-serial reflected crc-8 engine
// depends on crcbe_pkg, crcbe_in_stage and crcbe_core
//
// usage
//   request channel: req_valid/req_ready with req_data_byte, req_first_byte and
//   req_last_byte. one byte is taken per transfer. first_byte reloads the running
//   crc with 0xff before the byte; last_byte closes the message.
//   response channel: rsp_valid/rsp_ready with rsp_crc_value, one transfer per
//   message, carrying the crc including the last byte.
//   result path: a last byte taken into the input register is folded into the result
//   register once that register is free, and rsp_valid rises from the result register.
//   throughput: one byte per cycle while no last byte waits on rsp_ready; the fold is a
//   single pass through the eight-step table logic between the input and result registers.
//   reset: synchronous, active high; clears both valid flags and sets the running
//   crc to 0xff. after each last byte the running crc also returns to 0xff.
//   stalls: while a result waits on rsp_ready, bytes that are not last keep flowing;
//   a further last byte holds in the input register until the result is taken.

module crc8_reflected_byte_engine_unit
   import crcbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_crc_value
);

   byte_item_type req_item;
   byte_item_type stage_item;
   logic          stage_valid;
   logic          stage_take;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.first_byte = req_first_byte;
   assign req_item.last_byte  = req_last_byte;

   crcbe_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   crcbe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage_item    (stage_item),
      .stage_take    (stage_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule
